FILE: src/double_ended_queue_assert.svh
// Assertion macros shared by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge outside reset.
`define DQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a rising edge outside reset.
`define DQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: src/dq_pkg.sv
// Types and constants shared by the double-ended queue modules.
`default_nettype none

package dq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int ITEM_BITS_DEF = 32;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic exec;
        logic load;
    } dq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;
    } dq_sts_t;

endpackage

`default_nettype wire

FILE: src/double_ended_queue.sv
// Top level of the bounded double-ended queue (ring buffer of signed items).
`default_nettype none

// Double-ended queue of DEPTH signed items of ITEM_BITS bits, kept in a ring
// buffer in one RAM. Drive mode and item_value with start high while busy is
// low to hand in one beat: push front, push back, pop front or pop back. The
// result comes back as a single-cycle strobe on done, with status, the popped
// item, the front and back items after the operation, the count and the
// empty/full flags; the receiver cannot stall, so capture the result in the
// cycle that done is high. A pop on an empty queue reports underflow and a
// push on a full queue reports overflow; neither changes the queue.
// Timing: a push, a failed operation or a pop that empties the queue runs
// through ST_EXEC into ST_RESP, where done is high; a pop that leaves items
// behind passes through ST_LOAD between them, since the new end item must be
// fetched through the RAM's registered read port. A new beat is taken in the
// cycle that done is high, so beats are handled one at a time. The front and
// back items are cached in registers, so each operation needs at most one RAM
// access. There is no clearing pass after reset: a slot is only read after it
// has been written.
module double_ended_queue #(
    parameter int DEPTH     = dq_pkg::DEPTH_DEF,
    parameter int ITEM_BITS = dq_pkg::ITEM_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    output logic                            done,
    input  wire logic [1:0]                 mode,
    input  wire logic signed [31:0]         item_value,
    output logic      [1:0]                 status,
    output logic signed [31:0]              popped_value,
    output logic signed [31:0]              front_value,
    output logic signed [31:0]              back_value,
    output logic      [$clog2(DEPTH+1)-1:0] item_count,
    output logic                            is_empty,
    output logic                            is_full
);

    import dq_pkg::*;

    // command and status bundles between controller and datapath
    dq_cmd_t cmd;
    dq_sts_t sts;

    // Sequence each beat: latch, execute, optionally load, respond.
    dq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Hold the pointers, count, cached end items and the slot RAM.
    dq_datapath #(
        .DEPTH     (DEPTH),
        .ITEM_BITS (ITEM_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .item_value   (item_value),
        .status       (status),
        .popped_value (popped_value),
        .front_value  (front_value),
        .back_value   (back_value),
        .item_count   (item_count),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

endmodule

`default_nettype wire

FILE: src/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/dq_ctrl.sv
// Controller state machine that sequences one queue operation at a time.
`default_nettype none

`include "double_ended_queue_assert.svh"

module dq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire dq_pkg::dq_sts_t sts,
    output dq_pkg::dq_cmd_t      cmd,
    output logic                 busy,
    output logic                 done
);

    import dq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done       = 1'b0;
        busy       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                busy       = 1'b1;
                cmd.exec   = 1'b1;
                state_next = sts.need_read ? ST_LOAD : ST_RESP;
            end
            ST_LOAD:
            begin
                busy       = 1'b1;
                cmd.load   = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // result is held in registers; take the next beat at once
                done = 1'b1;
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `DQ_ASSERT(a_done_one_cycle, clk, rst_n, done && !start |=> !done, "done strobe held over two cycles without a new beat")
    `DQ_ASSERT(a_accept_runs, clk, rst_n, start && !busy |=> busy && !done, "accepted beat did not start execution")
    `DQ_ASSERT(a_load_after_read, clk, rst_n, cmd.exec && sts.need_read |=> cmd.load, "read data not loaded after a pop")

endmodule

`default_nettype wire

FILE: src/dq_datapath.sv
// Datapath: pointers, count, cached end items and the slot RAM.
`default_nettype none

`include "double_ended_queue_assert.svh"

module dq_datapath #(
    parameter int DEPTH     = dq_pkg::DEPTH_DEF,
    parameter int ITEM_BITS = dq_pkg::ITEM_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dq_pkg::dq_cmd_t            cmd,
    output dq_pkg::dq_sts_t                 sts,
    input  wire logic [1:0]                 mode,
    input  wire logic signed [31:0]         item_value,
    output logic      [1:0]                 status,
    output logic signed [31:0]              popped_value,
    output logic signed [31:0]              front_value,
    output logic signed [31:0]              back_value,
    output logic      [$clog2(DEPTH+1)-1:0] item_count,
    output logic                            is_empty,
    output logic                            is_full
);

    import dq_pkg::*;

    localparam int IDX_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int SUM_BITS = IDX_BITS + 1;

    mode_t                         op_mode_reg,  op_mode_next;
    logic signed [ITEM_BITS-1:0]   op_item_reg,  op_item_next;
    logic [IDX_BITS-1:0]           head_reg,     head_next;
    logic [CNT_BITS-1:0]           count_reg,    count_next;
    logic signed [ITEM_BITS-1:0]   front_reg,    front_next;
    logic signed [ITEM_BITS-1:0]   back_reg,     back_next;
    logic signed [ITEM_BITS-1:0]   popped_reg,   popped_next;
    status_t                       status_reg,   status_next;

    logic                 empty;
    logic                 full;
    logic                 is_pop;
    logic [IDX_BITS-1:0]  head_dec;
    logic [IDX_BITS-1:0]  head_inc;
    logic [SUM_BITS-1:0]  tail_sum;
    logic [IDX_BITS-1:0]  tail_slot;
    logic [SUM_BITS-1:0]  prev_sum;
    logic [IDX_BITS-1:0]  prev_slot;

    logic                 wr_en;
    logic [IDX_BITS-1:0]  wr_addr;
    logic                 rd_en;
    logic [IDX_BITS-1:0]  rd_addr;
    logic [ITEM_BITS-1:0] rd_data;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CNT_BITS'(DEPTH));
    assign is_pop = (op_mode_reg inside {MODE_POP_FRONT, MODE_POP_BACK});

    // Ring index arithmetic; every sum whose slot is used stays below twice the depth.
    assign head_dec  = (head_reg == '0) ? IDX_BITS'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc  = (head_reg == IDX_BITS'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum  = SUM_BITS'(head_reg) + SUM_BITS'(count_reg);
    assign tail_slot = (tail_sum >= SUM_BITS'(DEPTH)) ?
                       IDX_BITS'(tail_sum - SUM_BITS'(DEPTH)) : IDX_BITS'(tail_sum);
    assign prev_sum  = SUM_BITS'(head_reg) + SUM_BITS'(count_reg - CNT_BITS'(2));
    assign prev_slot = (prev_sum >= SUM_BITS'(DEPTH)) ?
                       IDX_BITS'(prev_sum - SUM_BITS'(DEPTH)) : IDX_BITS'(prev_sum);

    // A pop that leaves items behind must fetch the new end item.
    assign sts.need_read = is_pop && (count_reg >= CNT_BITS'(2));

    always_comb
    begin
        op_mode_next = op_mode_reg;
        op_item_next = op_item_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        front_next   = front_reg;
        back_next    = back_reg;
        popped_next  = popped_reg;
        status_next  = status_reg;
        wr_en        = 1'b0;
        wr_addr      = tail_slot;
        rd_en        = 1'b0;
        rd_addr      = head_inc;

        if (cmd.latch)
        begin
            op_mode_next = mode_t'(mode);
            op_item_next = ITEM_BITS'(item_value);
        end

        if (cmd.exec)
        begin
            status_next = STATUS_OK;
            popped_next = '0;
            case (op_mode_reg)
                MODE_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = head_dec;
                        head_next  = head_dec;
                        count_next = count_reg + 1'b1;
                        front_next = op_item_reg;
                        if (empty)
                        begin
                            back_next = op_item_reg;
                        end
                    end
                end
                MODE_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = tail_slot;
                        count_next = count_reg + 1'b1;
                        back_next  = op_item_reg;
                        if (empty)
                        begin
                            front_next = op_item_reg;
                        end
                    end
                end
                MODE_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        popped_next = front_reg;
                        head_next   = head_inc;
                        count_next  = count_reg - 1'b1;
                        rd_en       = sts.need_read;
                        rd_addr     = head_inc;
                    end
                end
                MODE_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        popped_next = back_reg;
                        count_next  = count_reg - 1'b1;
                        rd_en       = sts.need_read;
                        rd_addr     = prev_slot;
                    end
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end

        if (cmd.load)
        begin
            if (op_mode_reg == MODE_POP_FRONT)
            begin
                front_next = rd_data;
            end
            else
            begin
                back_next = rd_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_mode_reg <= op_mode_next;
        op_item_reg <= op_item_next;
        front_reg   <= front_next;
        back_reg    <= back_next;
        popped_reg  <= popped_next;
        status_reg  <= status_next;
    end

    dq_ram #(
        .WIDTH (ITEM_BITS),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (op_item_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign status       = status_reg;
    assign popped_value = 32'(popped_reg);
    assign front_value  = empty ? '0 : 32'(front_reg);
    assign back_value   = empty ? '0 : 32'(back_reg);
    assign item_count   = count_reg;
    assign is_empty     = empty;
    assign is_full      = full;

    `DQ_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_BITS'(DEPTH), "item count above depth")
    `DQ_ASSERT_NEVER(a_port_clash, clk, rst_n, wr_en && rd_en, "slot write and read in one cycle")
    `DQ_ASSERT(a_pop_count, clk, rst_n, cmd.exec && is_pop && !empty |=> count_reg == $past(count_reg) - 1'b1, "pop did not drop the count by one")
    `DQ_ASSERT(a_overflow_hold, clk, rst_n, cmd.exec && !is_pop && full |=> count_reg == $past(count_reg) && head_reg == $past(head_reg), "push on full queue changed the queue")

endmodule

`default_nettype wire
